// ----- rtl/core/pyuv_pkg.sv -----
// Shared types, constants and helpers for the planar YUV to packed UYVY block.
// No dependencies; imported by every module of the block but pyuv_queue.
package pyuv_pkg;

    localparam int MAX_PAIRS_DEF = 1024;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_PAIRS_PER_ROW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHROMA_MODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_SHIFT  = 2'd2;

    localparam logic [10:0] PAIRS_RST = 11'd320;

    // chroma sampling modes; the unused code behaves as 4:2:2
    localparam logic [1:0] MODE_420 = 2'd0;
    localparam logic [1:0] MODE_410 = 2'd1;
    localparam logic [1:0] MODE_422 = 2'd2;

    // per-beat control and byte payload, front to back
    typedef struct packed {
        logic       wr_chroma;
        logic       row_end;
        logic [7:0] u;
        logic [7:0] v;
        logic [7:0] y0;
        logic [7:0] y1;
    } t_ctl;

    localparam int CTL_W = $bits(t_ctl);

    function automatic logic [7:0] f_reduce(input logic [15:0] s, input logic [3:0] sh);
        logic [15:0] t;
        t = s >> sh;
        return t[7:0];
    endfunction

endpackage

// ----- rtl/core/pyuv_front.sv -----
// Front end: configuration registers, row position tracking and beat classification.
// Depends on pyuv_pkg.
module pyuv_front #(
    parameter int MAX_PAIRS = pyuv_pkg::MAX_PAIRS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [pyuv_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pyuv_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_accept,
    input  logic [15:0]                     i_luma_first,
    input  logic [15:0]                     i_luma_second,
    input  logic [15:0]                     i_chroma_blue,
    input  logic [15:0]                     i_chroma_red,
    output logic [$clog2(MAX_PAIRS)-1:0]    o_slot,
    output pyuv_pkg::t_ctl                  o_ctl
);
    import pyuv_pkg::*;

    localparam int IW  = $clog2(MAX_PAIRS);
    localparam int LW0 = $clog2(MAX_PAIRS + 1);
    localparam int CW  = (LW0 > CFG_DATA_W) ? LW0 : CFG_DATA_W;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_PAIRS);

    logic [10:0]   r_pairs;
    logic [1:0]    r_mode;
    logic [3:0]    r_shift;
    logic [IW-1:0] r_pair_idx, n_pair_idx;
    logic [1:0]    r_row_phase, n_row_phase;

    logic [CW-1:0] pairs_ext, row_len, idx_inc;
    logic          last;
    logic          wr_now;
    logic [IW-1:0] slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pairs <= PAIRS_RST;
            r_mode  <= MODE_420;
            r_shift <= 4'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PAIRS_PER_ROW: r_pairs <= i_cfg_data;
                CFG_CHROMA_MODE:   r_mode  <= i_cfg_data[1:0];
                CFG_SAMPLE_SHIFT:  r_shift <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // effective row length: zero reads as one, clamp at the store depth
    always_comb begin
        pairs_ext = CW'(r_pairs);
        if (pairs_ext == '0) begin
            row_len = CW'(1);
        end else if (pairs_ext > MAX_C) begin
            row_len = MAX_C;
        end else begin
            row_len = pairs_ext;
        end
        idx_inc = CW'(r_pair_idx) + CW'(1);
        last    = (idx_inc >= row_len);
    end

    always_comb begin
        unique case (r_mode)
            MODE_420: begin
                wr_now = ~r_row_phase[0];
                slot   = r_pair_idx;
            end
            MODE_410: begin
                wr_now = (r_row_phase == 2'd0) && ~r_pair_idx[0];
                slot   = r_pair_idx >> 1;
            end
            default: begin
                wr_now = 1'b1;
                slot   = r_pair_idx;
            end
        endcase
    end

    always_comb begin
        n_pair_idx  = r_pair_idx;
        n_row_phase = r_row_phase;
        if (i_accept) begin
            if (last) begin
                n_pair_idx  = '0;
                n_row_phase = r_row_phase + 2'd1;
            end else begin
                n_pair_idx  = r_pair_idx + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_idx  <= '0;
            r_row_phase <= '0;
        end else begin
            r_pair_idx  <= n_pair_idx;
            r_row_phase <= n_row_phase;
        end
    end

    assign o_slot        = slot;
    assign o_ctl.wr_chroma = wr_now;
    assign o_ctl.row_end = last;
    assign o_ctl.u       = f_reduce(i_chroma_blue, r_shift);
    assign o_ctl.v       = f_reduce(i_chroma_red, r_shift);
    assign o_ctl.y0      = f_reduce(i_luma_first, r_shift);
    assign o_ctl.y1      = f_reduce(i_luma_second, r_shift);

endmodule

// ----- rtl/core/pyuv_queue.sv -----
// Two-entry beat queue between front and back.
// Depends on nothing outside this file.
module pyuv_queue #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_valid,
    output logic              o_full
);
    logic [DATA_W-1:0] r_mem [2];
    logic              r_wr_ptr, r_rd_ptr;
    logic [1:0]        r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (i_pop)  r_rd_ptr <= ~r_rd_ptr;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);

endmodule

// ----- rtl/core/pyuv_back.sv -----
// Back end: chroma line store access and the registered output beat.
// Depends on pyuv_pkg.
module pyuv_back #(
    parameter int MAX_PAIRS = pyuv_pkg::MAX_PAIRS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  logic [$clog2(MAX_PAIRS)-1:0] i_slot,
    input  pyuv_pkg::t_ctl               i_ctl,
    output logic                         o_pop,
    input  logic                         i_out_stall,
    output logic                         o_out_valid,
    output logic [7:0]                   o_out_u,
    output logic [7:0]                   o_out_y0,
    output logic [7:0]                   o_out_v,
    output logic [7:0]                   o_out_y1,
    output logic                         o_row_end
);
    import pyuv_pkg::*;

    logic [15:0] r_line [MAX_PAIRS];
    logic [15:0] r_rd_data;
    logic [15:0] r_wr_data;
    logic        r_bypass;
    logic [7:0]  r_y0, r_y1;
    logic        r_row_end;
    logic        r_valid;
    logic        pop;

    assign pop = i_q_valid && (!r_valid || !i_out_stall);

    // V in the high byte, U in the low byte
    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (i_ctl.wr_chroma) begin
                r_line[i_slot] <= {i_ctl.v, i_ctl.u};
            end
            r_rd_data <= r_line[i_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_wr_data <= {i_ctl.v, i_ctl.u};
            r_bypass  <= i_ctl.wr_chroma;
            r_y0      <= i_ctl.y0;
            r_y1      <= i_ctl.y1;
            r_row_end <= i_ctl.row_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    assign o_pop       = pop;
    assign o_out_valid = r_valid;
    assign o_out_u     = r_bypass ? r_wr_data[7:0]  : r_rd_data[7:0];
    assign o_out_v     = r_bypass ? r_wr_data[15:8] : r_rd_data[15:8];
    assign o_out_y0    = r_y0;
    assign o_out_y1    = r_y1;
    assign o_row_end   = r_row_end;

endmodule

// ----- rtl/core/planar_yuv_to_packed_uyvy_top.sv -----
// Top level of the planar YUV to packed UYVY converter with chroma line replication.
// Depends on pyuv_pkg, pyuv_front, pyuv_queue and pyuv_back.
//
// One beat in carries a horizontal luma pair in raster order plus the chroma
// at that position; one beat out carries the packed quad U,Y0,V,Y1 and a
// row_end flag on the last pair of each row. Every sample is shifted right by
// sample_shift and its low byte kept. Chroma is taken fresh on every second
// row (4:2:0), every fourth row with one chroma sample per two pairs (4:1:0)
// or every row (4:2:2), and replayed from a MAX_PAIRS x 16 line store on the
// other rows. The block sustains one beat per clock while the output is not
// stalled: the single-port line store is addressed at one slot per beat, and a
// beat passes through the queue register, then the store read and output
// register. A two-entry queue sits between the front end and the store stage,
// so input accepts carry on while a result waits on a stalled output. The
// line store has no clearing pass; a non-fresh row must follow a fresh one.
// Configuration writes are always ready and should be made while the block is idle.
module planar_yuv_to_packed_uyvy_top #(
    parameter int MAX_PAIRS = pyuv_pkg::MAX_PAIRS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pyuv_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pyuv_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input beat channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [15:0]                     i_luma_first,
    input  logic [15:0]                     i_luma_second,
    input  logic [15:0]                     i_chroma_blue,
    input  logic [15:0]                     i_chroma_red,
    // output beat channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [7:0]                      o_out_u,
    output logic [7:0]                      o_out_y0,
    output logic [7:0]                      o_out_v,
    output logic [7:0]                      o_out_y1,
    output logic                            o_row_end
);
    import pyuv_pkg::*;

    localparam int IW = $clog2(MAX_PAIRS);
    localparam int QW = IW + CTL_W;

    logic          in_accept;
    logic          q_full, q_valid, q_pop;
    logic [IW-1:0] f_slot, b_slot;
    t_ctl          f_ctl, b_ctl;
    logic [QW-1:0] q_rd_data;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;
    assign in_accept   = i_in_valid && !q_full;

    // front end: row position, fresh-row decision, sample reduction
    pyuv_front #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (in_accept),
        .i_luma_first  (i_luma_first),
        .i_luma_second (i_luma_second),
        .i_chroma_blue (i_chroma_blue),
        .i_chroma_red  (i_chroma_red),
        .o_slot        (f_slot),
        .o_ctl         (f_ctl)
    );

    pyuv_queue #(
        .DATA_W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_data  ({f_slot, f_ctl}),
        .i_pop   (q_pop),
        .o_data  (q_rd_data),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    assign b_slot = q_rd_data[QW-1:CTL_W];
    assign b_ctl  = t_ctl'(q_rd_data[CTL_W-1:0]);

    // back end: line store write or read, output register
    pyuv_back #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_slot      (b_slot),
        .i_ctl       (b_ctl),
        .o_pop       (q_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_u     (o_out_u),
        .o_out_y0    (o_out_y0),
        .o_out_v     (o_out_v),
        .o_out_y1    (o_out_y1),
        .o_row_end   (o_row_end)
    );

    // an accepted beat is queued on the next cycle
    a_accept_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> q_valid)
        else $error("accepted beat missing from queue");

    // a beat taken from the queue shows on the output next cycle
    a_pop_presented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> o_out_valid)
        else $error("popped beat not presented");

    // never pop an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    // reset leaves the output empty and the input open
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("reset did not clear the pipeline");

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for planar_yuv_to_packed_uyvy_top: a directed table, then random frames.
// Depends on pyuv_pkg and the RTL of the block; needs no file and no argument.
`timescale 1ns / 100ps

module tb;

    import pyuv_pkg::*;

    // Block geometry and run shape
    localparam int MAX_PAIRS  = MAX_PAIRS_DEF;
    localparam int RAND_BEATS = 300;
    localparam int DRAIN      = 8;        // idle clocks after the last expected beat has come out
    localparam int PLAN_ROWS  = 33;

    // Unused mode code; the block treats it as 4:2:2
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // Shifts that real sources use, favoured in the random part
    localparam logic [3:0] USUAL_SHIFTS [4] = '{4'd0, 4'd1, 4'd2, 4'd8};

    // One packed output beat, U,Y0,V,Y1 plus the end-of-row flag
    typedef struct packed {
        logic [7:0] u;
        logic [7:0] y0;
        logic [7:0] v;
        logic [7:0] y1;
        logic       row_end;
    } t_uyvy_quad;

    typedef enum logic {ROW_CFG, ROW_BEAT} t_step_kind;

    // One row of the directed table: either a register write or an input beat.
    // Where 'typed' is set, 'quad' is the expected beat read straight off the spec.
    typedef struct packed {
        t_step_kind            kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [15:0]           lf;
        logic [15:0]           ls;
        logic [15:0]           cb;
        logic [15:0]           cr;
        logic                  typed;
        t_uyvy_quad            quad;
    } t_plan_row;

    // Directed part. Reset state is 320 pairs, 4:2:0, no shift.
    localparam t_plan_row PLAN [PLAN_ROWS] = '{
        // first beat after reset: fresh chroma row, plain low bytes
        '{ROW_BEAT, '0, '0, 16'h1234, 16'hABCD, 16'h00FF, 16'hFF00, 1'b1,
          '{8'hFF, 8'h34, 8'h00, 8'hCD, 1'b0}},
        // row length zero behaves as one; index already beyond, so the row ends now
        '{ROW_CFG, CFG_PAIRS_PER_ROW, 11'd0, '0, '0, '0, '0, 1'b0, '0},
        '{ROW_BEAT, '0, '0, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 1'b1,
          '{8'hFF, 8'hFF, 8'h00, 8'h00, 1'b1}},
        // odd row of 4:2:0 replays slot 0, chroma inputs ignored
        '{ROW_BEAT, '0, '0, 16'h0000, 16'hFFFF, 16'h1234, 16'h5678, 1'b1,
          '{8'hFF, 8'h00, 8'h00, 8'hFF, 1'b1}},
        '{ROW_BEAT, '0, '0, 16'h0F0F, 16'hF0F0, 16'h5555, 16'hAAAA, 1'b0, '0},
        '{ROW_BEAT, '0, '0, 16'h8001, 16'h7FFE, 16'h0001, 16'hFFFE, 1'b0, '0},
        // 4:1:0, three pairs per row, top byte of deep samples
        '{ROW_CFG, CFG_SAMPLE_SHIFT, 11'd8, '0, '0, '0, '0, 1'b0, '0},
        '{ROW_CFG, CFG_PAIRS_PER_ROW, 11'd3, '0, '0, '0, '0, 1'b0, '0},
        '{ROW_CFG, CFG_CHROMA_MODE, 11'(MODE_410), '0, '0, '0, '0, 1'b0, '0},
        '{ROW_BEAT, '0, '0, 16'hFF00, 16'h00FF, 16'hA5C3, 16'h3CA5, 1'b0, '0},
        '{ROW_BEAT, '0, '0, 16'h1200, 16'h3400, 16'hFFFF, 16'hFFFF, 1'b0, '0},
        '{ROW_BEAT, '0, '0, 16'h5600, 16'h7800, 16'h0100, 16'hFE00, 1'b0, '0},
        '{ROW_BEAT, '0, '0, 16'h9A00, 16'hBC00, 16'h0000, 16'h0000, 1'b0, '0},
        '{ROW_BEAT, '0, '0, 16'hDE00, 16'hF000, 16'h7777, 16'h8888, 1'b0, '0},
        '{ROW_BEAT, '0, '0, 16'h0100, 16'h0200, 16'h9999, 16'h6666, 1'b0, '0},
        '{ROW_BEAT, '0, '0, 16'hFFFF, 16'hFFFF, 16'h4242, 16'h2424, 1'b0, '0},
        '{ROW_BEAT, '0, '0, 16'h0000, 16'h0000, 16'hC0DE, 16'hBEEF, 1'b0, '0},
        '{ROW_BEAT, '0, '0, 16'h8080, 16'h0808, 16'h1111, 16'h2222, 1'b0, '0},
        '{ROW_BEAT, '0, '0, 16'h7F7F, 16'hF7F7, 16'h3333, 16'h4444, 1'b0, '0},
        '{ROW_BEAT, '0, '0, 16'h4000, 16'h2000, 16'h5A5A, 16'hA5A5, 1'b0, '0},
        '{ROW_BEAT, '0, '0, 16'h1000, 16'h0800, 16'hE1E1, 16'h1E1E, 1'b0, '0},
        // spare mode code acts as 4:2:2; shift of 15 leaves bit 15 only
        '{ROW_CFG, CFG_CHROMA_MODE, 11'(MODE_SPARE), '0, '0, '0, '0, 1'b0, '0},
        '{ROW_CFG, CFG_SAMPLE_SHIFT, 11'd15, '0, '0, '0, '0, 1'b0, '0},
        '{ROW_CFG, CFG_PAIRS_PER_ROW, 11'd5, '0, '0, '0, '0, 1'b0, '0},
        '{ROW_BEAT, '0, '0, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b1,
          '{8'h01, 8'h01, 8'h00, 8'h00, 1'b0}},
        '{ROW_BEAT, '0, '0, 16'hC000, 16'h4000, 16'hFFFF, 16'h8001, 1'b0, '0},
        // row shortened mid-row: index 2 lies beyond the new last pair
        '{ROW_CFG, CFG_PAIRS_PER_ROW, 11'd2, '0, '0, '0, '0, 1'b0, '0},
        '{ROW_BEAT, '0, '0, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1,
          '{8'h01, 8'h00, 8'h00, 8'h01, 1'b1}},
        '{ROW_CFG, CFG_SAMPLE_SHIFT, 11'd1, '0, '0, '0, '0, 1'b0, '0},
        '{ROW_CFG, CFG_CHROMA_MODE, 11'(MODE_422), '0, '0, '0, '0, 1'b0, '0},
        '{ROW_CFG, CFG_PAIRS_PER_ROW, 11'd1, '0, '0, '0, '0, 1'b0, '0},
        '{ROW_BEAT, '0, '0, 16'h01FE, 16'hFE01, 16'h0003, 16'hFFFC, 1'b0, '0},
        '{ROW_BEAT, '0, '0, 16'h3C3C, 16'hC3C3, 16'h6969, 16'h9696, 1'b0, '0}
    };

    // Clock, reset and every input of the block, known from time zero
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  i_in_valid    = 1'b0;
    logic [15:0]           i_luma_first  = '0;
    logic [15:0]           i_luma_second = '0;
    logic [15:0]           i_chroma_blue = '0;
    logic [15:0]           i_chroma_red  = '0;
    logic                  i_out_stall   = 1'b0;

    logic       o_cfg_ready;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_out_u;
    logic [7:0] o_out_y0;
    logic [7:0] o_out_v;
    logic [7:0] o_out_y1;
    logic       o_row_end;

    // Predictor's own copy of the registers and of the line state
    logic [10:0] cfg_pairs = PAIRS_RST;
    logic [1:0]  cfg_mode  = MODE_420;
    logic [3:0]  cfg_shift = 4'd0;
    logic [15:0] chroma_store [MAX_PAIRS];  // left unknown: an unwritten read shows as a mismatch
    int unsigned pair_pos  = 0;
    logic [1:0]  row_ph    = 2'd0;

    t_uyvy_quad pending_quads [$];          // beats accepted in, not yet seen out
    int         faults     = 0;
    int         rand_beats = 0;
    bit         calm       = 1'b0;          // no idling on either side while set

    planar_yuv_to_packed_uyvy_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_luma_first  (i_luma_first),
        .i_luma_second (i_luma_second),
        .i_chroma_blue (i_chroma_blue),
        .i_chroma_red  (i_chroma_red),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_u       (o_out_u),
        .o_out_y0      (o_out_y0),
        .o_out_v       (o_out_v),
        .o_out_y1      (o_out_y1),
        .o_row_end     (o_row_end)
    );

    // 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report_fault(input string msg);
        $display("%0t: %s", $realtime, msg);
        faults++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_fault($sformatf("%s got %h, expected %h", name, got, want));
    endtask

    // Shift a deep sample down and keep its low byte
    function automatic logic [7:0] shrink_sample(input logic [15:0] s);
        logic [15:0] t;
        t = s >> cfg_shift;
        return t[7:0];
    endfunction

    // Expected beat for one accepted pair; advances the line state
    function automatic t_uyvy_quad predict_quad(input logic [15:0] lf, input logic [15:0] ls,
                                                input logic [15:0] cb, input logic [15:0] cr);
        int unsigned len;
        int unsigned pos;
        int unsigned slot;
        logic        wr;
        t_uyvy_quad  q;
        len = cfg_pairs;
        if (len == 0) len = 1;
        if (len > MAX_PAIRS) len = MAX_PAIRS;
        pos = (pair_pos >= MAX_PAIRS) ? MAX_PAIRS - 1 : pair_pos;
        case (cfg_mode)
            MODE_420: begin
                slot = pos;
                wr   = !row_ph[0];
            end
            MODE_410: begin
                slot = pos >> 1;
                wr   = (row_ph == 2'd0) && !pos[0];
            end
            default: begin
                slot = pos;
                wr   = 1'b1;
            end
        endcase
        // fresh chroma lands in the store first, the beat then reads it back
        if (wr) chroma_store[slot] = {shrink_sample(cr), shrink_sample(cb)};
        q.u       = chroma_store[slot][7:0];
        q.v       = chroma_store[slot][15:8];
        q.y0      = shrink_sample(lf);
        q.y1      = shrink_sample(ls);
        q.row_end = (pos + 1 >= len);
        if (q.row_end) begin
            pair_pos = 0;
            row_ph   = row_ph + 2'd1;
        end else begin
            pair_pos = pos + 1;
        end
        return q;
    endfunction

    // Present one input beat, with an optional idle gap first; holds until accepted
    task automatic send_beat(input logic [15:0] lf, input logic [15:0] ls,
                             input logic [15:0] cb, input logic [15:0] cr,
                             input logic typed, input t_uyvy_quad typed_quad);
        t_uyvy_quad q;
        while (!calm && $urandom_range(99) < 15) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_luma_first  <= lf;
        i_luma_second <= ls;
        i_chroma_blue <= cb;
        i_chroma_red  <= cr;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        q = predict_quad(lf, ls, cb, cr);
        pending_quads.push_back(typed ? typed_quad : q);
    endtask

    task automatic send_random_pair();
        send_beat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'b0, '0);
        rand_beats++;
        calm = (rand_beats >= 100 && rand_beats < 250);
    endtask

    // Register write, only once every beat in flight has come out
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_in_valid <= 1'b0;
        while (pending_quads.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        case (idx)
            CFG_PAIRS_PER_ROW: cfg_pairs = val;
            CFG_CHROMA_MODE:   cfg_mode  = val[1:0];
            CFG_SAMPLE_SHIFT:  cfg_shift = val[3:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Feed random pairs until a new setting cannot make a row replay store
    // entries never written: row start, and for 4:2:0 / 4:1:0 also frame start.
    task automatic settle_rows(input logic [1:0] next_mode);
        while (pair_pos != 0 ||
               ((next_mode == MODE_420 || next_mode == MODE_410) && row_ph != 2'd0))
            send_random_pair();
    endtask

    // Output side: check each accepted beat, stall at random
    always @(posedge i_clk) begin : out_side
        t_uyvy_quad want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (pending_quads.size() == 0) begin
                report_fault("output beat with nothing expected");
            end else begin
                want = pending_quads.pop_front();
                check_field("out_u", o_out_u, want.u);
                check_field("out_y0", o_out_y0, want.y0);
                check_field("out_v", o_out_v, want.v);
                check_field("out_y1", o_out_y1, want.y1);
                check_field("row_end", 8'(o_row_end), 8'(want.row_end));
            end
        end
        i_out_stall <= !calm && ($urandom_range(99) < 15);
    end

    initial begin : stimulus
        int unsigned n;
        int unsigned r;
        logic [10:0] len_v;
        logic [1:0]  mode_v;
        logic [3:0]  shift_v;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (PLAN[k]) begin
            if (PLAN[k].kind == ROW_CFG)
                write_reg(PLAN[k].reg_idx, PLAN[k].reg_val);
            else
                send_beat(PLAN[k].lf, PLAN[k].ls, PLAN[k].cb, PLAN[k].cr,
                          PLAN[k].typed, PLAN[k].quad);
        end

        // Random frames: short rows mostly, now and then length zero
        while (rand_beats < RAND_BEATS) begin
            r = $urandom_range(99);
            if (r < 5)
                len_v = 11'd0;
            else if (r < 70)
                len_v = 11'($urandom_range(8, 1));
            else
                len_v = 11'($urandom_range(40, 9));
            mode_v = 2'($urandom_range(3));
            if ($urandom_range(99) < 50)
                shift_v = USUAL_SHIFTS[$urandom_range(3)];
            else
                shift_v = 4'($urandom_range(15));
            settle_rows(mode_v);
            write_reg(CFG_PAIRS_PER_ROW, len_v);
            write_reg(CFG_CHROMA_MODE, 11'(mode_v));
            write_reg(CFG_SAMPLE_SHIFT, 11'(shift_v));
            n = $urandom_range(150, 20);
            repeat (n) send_random_pair();
        end

        // One full-width row: an all-ones length saturates to the store depth
        settle_rows(MODE_422);
        write_reg(CFG_PAIRS_PER_ROW, 11'h7FF);
        write_reg(CFG_CHROMA_MODE, 11'(MODE_422));
        repeat (MAX_PAIRS) send_random_pair();

        i_in_valid <= 1'b0;
        while (pending_quads.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (faults == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
